// ===== rtl/core/utf8_byte_stream_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_defines
// Assertion macros shared by the decoder RTL; compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_STREAM_DECODER_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF

// condition must hold in the same cycle as the trigger
`define UTF8_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("utf8 decoder check failed");

// condition must hold in the cycle after the trigger
`define UTF8_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("utf8 decoder check failed");

`else

`define UTF8_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define UTF8_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

// ===== rtl/core/utf8_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8_pkg
// Types, constants and range check shared by the UTF-8 decoder files
// ----------------------------------------------------------------------------
package utf8_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int REM_W  = 2;

    // byte class masks and patterns
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_PAT  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
    localparam logic [BYTE_W-1:0] PAYLOAD6_MASK = 8'h3F;

    // sequence lengths, counted in continuation bytes
    localparam logic [REM_W-1:0] SEQ_NONE = 2'd0;
    localparam logic [REM_W-1:0] SEQ_TWO  = 2'd1;
    localparam logic [REM_W-1:0] SEQ_THREE = 2'd2;
    localparam logic [REM_W-1:0] SEQ_FOUR = 2'd3;

    // legal value ranges per sequence length
    localparam logic [CP_W-1:0] MIN_TWO   = 21'h00080;
    localparam logic [CP_W-1:0] MAX_TWO   = 21'h007FF;
    localparam logic [CP_W-1:0] MIN_THREE = 21'h00800;
    localparam logic [CP_W-1:0] MAX_THREE = 21'h0FFFF;
    localparam logic [CP_W-1:0] MIN_FOUR  = 21'h10000;
    localparam logic [CP_W-1:0] MAX_FOUR  = 21'h10FFFF;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = 2;
    localparam int CNT_W = 3;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            invalid;
        logic            run_last;
    } result_t;

    // overlong or out-of-range check for a finished sequence
    function automatic logic range_bad(input logic [REM_W-1:0] seq_len,
                                       input logic [CP_W-1:0]  value);
        logic bad;
        unique case (seq_len)
            SEQ_TWO:   bad = (value < MIN_TWO)   || (value > MAX_TWO);
            SEQ_THREE: bad = (value < MIN_THREE) || (value > MAX_THREE);
            default:   bad = (value < MIN_FOUR)  || (value > MAX_FOUR);
        endcase
        return bad;
    endfunction

endpackage

// ===== rtl/core/utf8_byte_if.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_if
// Valid/ready channel carrying one raw text byte per transaction
// ----------------------------------------------------------------------------
interface utf8_byte_if;
    import utf8_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// ===== rtl/core/utf8_cp_if.sv =====
// ----------------------------------------------------------------------------
// utf8_cp_if
// Valid/ready channel carrying one decoded code point per transaction
// ----------------------------------------------------------------------------
interface utf8_cp_if;
    import utf8_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            invalid;
    logic            run_last;

    modport source (output valid, output code_point, output invalid, output run_last,
                    input ready);
    modport sink   (input valid, input code_point, input invalid, input run_last,
                    output ready);
endinterface

// ===== rtl/core/utf8_byte_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// UTF-8 byte stream to code point decoder; while ready, one byte per cycle
// ----------------------------------------------------------------------------
//  channel   dir  payload                             per transaction
//  byte_ch   in   byte_in[7:0]                        one text byte
//  cp_ch     out  code_point[20:0] invalid run_last   one result
//
//  One byte is accepted per cycle; its zero, one or two results are decoded
//  in the same cycle into a four-entry result queue, visible the next cycle.
//  byte_ch.ready is high while the queue has room for two results, so the
//  input stalls only when the output side has not drained.
//  Results leave the queue head at one per cycle while cp_ch.ready is high.
//  Reset clears the sequence state and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
`include "utf8_byte_stream_decoder_defines.svh"

module utf8_byte_stream_decoder (
    input  logic            clk,
    input  logic            rst_n,
    utf8_byte_if.sink       byte_ch,
    utf8_cp_if.source       cp_ch
);
    import utf8_pkg::*;

    // sequence state
    logic [CP_W-1:0]  code_reg,   code_next;
    logic [REM_W-1:0] remain_reg, remain_next;
    logic [REM_W-1:0] len_reg,    len_next;

    // result queue
    result_t          fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg,  count_next;

    // decode results for the current byte
    result_t          res0, res1, fresh_res;
    logic [1:0]       n_res;
    logic             fresh, fresh_has;
    logic             is_cont;
    logic [CP_W-1:0]  shifted;
    logic             in_acc, out_pop;
    logic [PTR_W-1:0] wr_ptr_inc;

    // check terms
    logic             eot_idle, stray_cont, len_ok;

    assign in_acc  = byte_ch.valid && byte_ch.ready;
    assign out_pop = cp_ch.valid && cp_ch.ready;
    assign is_cont = (byte_ch.byte_in & CONT_MASK) == CONT_PAT;
    assign shifted = {code_reg[CP_W-7:0], byte_ch.byte_in[5:0]};

    // combinational decode of one byte
    always_comb
    begin
        code_next   = code_reg;
        remain_next = remain_reg;
        len_next    = len_reg;
        res0        = '0;
        res1        = '0;
        fresh_res   = '0;
        fresh_has   = 1'b0;
        n_res       = 2'd0;
        fresh       = 1'b1;

        // pending sequence: continue, finish or break it
        if (remain_reg != SEQ_NONE)
        begin
            if (is_cont)
            begin
                fresh       = 1'b0;
                code_next   = shifted;
                remain_next = remain_reg - 2'd1;
                if (remain_reg == 2'd1)
                begin
                    res0.invalid    = range_bad(len_reg, shifted);
                    res0.code_point = res0.invalid ? '0 : shifted;
                    n_res           = 2'd1;
                    code_next       = '0;
                    len_next        = SEQ_NONE;
                end
            end
            else
            begin
                res0.invalid = 1'b1;
                n_res        = 2'd1;
                code_next    = '0;
                remain_next  = SEQ_NONE;
                len_next     = SEQ_NONE;
            end
        end

        // fresh decode of a lead or single byte
        if (fresh)
        begin
            priority if (byte_ch.byte_in == '0)
            begin
                fresh_has = 1'b0;
            end
            else if (!byte_ch.byte_in[7])
            begin
                fresh_has            = 1'b1;
                fresh_res.code_point = CP_W'(byte_ch.byte_in);
            end
            else if ((byte_ch.byte_in & LEAD2_MASK) == LEAD2_PAT)
            begin
                code_next   = CP_W'(byte_ch.byte_in[4:0]);
                remain_next = SEQ_TWO;
                len_next    = SEQ_TWO;
            end
            else if ((byte_ch.byte_in & LEAD3_MASK) == LEAD3_PAT)
            begin
                code_next   = CP_W'(byte_ch.byte_in[3:0]);
                remain_next = SEQ_THREE;
                len_next    = SEQ_THREE;
            end
            else if ((byte_ch.byte_in & LEAD4_MASK) == LEAD4_PAT)
            begin
                code_next   = CP_W'(byte_ch.byte_in[2:0]);
                remain_next = SEQ_FOUR;
                len_next    = SEQ_FOUR;
            end
            else
            begin
                fresh_has         = 1'b1;
                fresh_res.invalid = 1'b1;
            end

            if (fresh_has)
            begin
                if (n_res == 2'd0)
                begin
                    res0  = fresh_res;
                    n_res = 2'd1;
                end
                else
                begin
                    res1  = fresh_res;
                    n_res = 2'd2;
                end
            end
        end

        // mark the final result of this byte
        if (n_res == 2'd1)
        begin
            res0.run_last = 1'b1;
        end
        if (n_res == 2'd2)
        begin
            res1.run_last = 1'b1;
        end
    end

    // sequence state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg   <= '0;
            remain_reg <= SEQ_NONE;
            len_reg    <= SEQ_NONE;
        end
        else if (in_acc)
        begin
            code_reg   <= code_next;
            remain_reg <= remain_next;
            len_reg    <= len_next;
        end
    end

    // queue pointers and fill count
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);
    assign count_next = count_reg + (in_acc ? CNT_W'(n_res) : '0) - CNT_W'(out_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            end
            if (out_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // queue storage, up to two writes per transaction
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FIFO_DEPTH; i++)
        begin
            if (in_acc && (n_res != 2'd0) && (wr_ptr_reg == PTR_W'(i)))
            begin
                fifo_reg[i] <= res0;
            end
            if (in_acc && (n_res == 2'd2) && (wr_ptr_inc == PTR_W'(i)))
            begin
                fifo_reg[i] <= res1;
            end
        end
    end

    // channel outputs
    assign byte_ch.ready    = count_reg <= CNT_W'(FIFO_DEPTH - 2);
    assign cp_ch.valid      = count_reg != '0;
    assign cp_ch.code_point = fifo_reg[rd_ptr_reg].code_point;
    assign cp_ch.invalid    = fifo_reg[rd_ptr_reg].invalid;
    assign cp_ch.run_last   = fifo_reg[rd_ptr_reg].run_last;

    // checks
    assign eot_idle   = in_acc && (remain_reg == SEQ_NONE) && (byte_ch.byte_in == '0)
                        && !out_pop;
    assign stray_cont = in_acc && (remain_reg == SEQ_NONE) && is_cont;
    assign len_ok     = (len_reg != SEQ_NONE) && (remain_reg <= len_reg);

    `UTF8_ASSERT_SAME(a_err_zero, clk, rst_n, cp_ch.valid && cp_ch.invalid, cp_ch.code_point == '0)
    `UTF8_ASSERT_SAME(a_no_overflow, clk, rst_n, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH))
    `UTF8_ASSERT_SAME(a_remain_le_len, clk, rst_n, remain_reg != SEQ_NONE, len_ok)
    `UTF8_ASSERT_NEXT(a_eot_quiet, clk, rst_n, eot_idle, count_reg == $past(count_reg))
    `UTF8_ASSERT_NEXT(a_cont_idle_err, clk, rst_n, stray_cont, remain_reg == SEQ_NONE)

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 byte stream decoder: a scoreboard class
// predicts code point results per accepted byte, while directed and random
// byte streams are pushed through under varying sender gaps and receiver
// stalls, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 1400;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    // expected code point results, predicted byte by byte
    class code_point_scoreboard;
        logic [CP_W-1:0]  partial_code;
        logic [REM_W-1:0] cont_left;
        logic [REM_W-1:0] seq_len;
        result_t          pending_cps[$];
        int               error_count;

        function new();
            partial_code = '0;
            cont_left    = SEQ_NONE;
            seq_len      = SEQ_NONE;
            error_count  = 0;
        endfunction

        function void push_cp(logic [CP_W-1:0] cp, logic bad);
            result_t r;
            r.code_point = bad ? '0 : cp;
            r.invalid    = bad;
            r.run_last   = 1'b0;
            pending_cps.push_back(r);
        endfunction

        // predict the results caused by one accepted byte
        function void note_byte(logic [BYTE_W-1:0] b);
            int   first_new;
            logic consumed;
            logic bad;
            first_new = pending_cps.size();
            consumed  = 1'b0;
            if (cont_left != SEQ_NONE) begin
                if ((b & CONT_MASK) == CONT_PAT) begin
                    consumed     = 1'b1;
                    partial_code = {partial_code[CP_W-7:0], b[5:0]};
                    cont_left    = cont_left - 1'b1;
                    if (cont_left == SEQ_NONE) begin
                        case (seq_len)
                            SEQ_TWO:   bad = (partial_code < MIN_TWO) ||
                                             (partial_code > MAX_TWO);
                            SEQ_THREE: bad = (partial_code < MIN_THREE) ||
                                             (partial_code > MAX_THREE);
                            default:   bad = (partial_code < MIN_FOUR) ||
                                             (partial_code > MAX_FOUR);
                        endcase
                        push_cp(partial_code, bad);
                        partial_code = '0;
                        seq_len      = SEQ_NONE;
                    end
                end else begin
                    // interrupted sequence, the byte is decoded afresh below
                    push_cp('0, 1'b1);
                    partial_code = '0;
                    cont_left    = SEQ_NONE;
                    seq_len      = SEQ_NONE;
                end
            end
            if (!consumed) begin
                if (b == '0) begin
                    // end of text: no result
                end else if (b[7] == 1'b0) begin
                    push_cp(CP_W'(b), 1'b0);
                end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
                    partial_code = CP_W'(b[4:0]);
                    cont_left    = SEQ_TWO;
                    seq_len      = SEQ_TWO;
                end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
                    partial_code = CP_W'(b[3:0]);
                    cont_left    = SEQ_THREE;
                    seq_len      = SEQ_THREE;
                end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
                    partial_code = CP_W'(b[2:0]);
                    cont_left    = SEQ_FOUR;
                    seq_len      = SEQ_FOUR;
                end else begin
                    // stray continuation or 11111xxx lead
                    push_cp('0, 1'b1);
                end
            end
            if (pending_cps.size() > first_new)
                pending_cps[pending_cps.size()-1].run_last = 1'b1;
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(result_t got);
            result_t want;
            if (pending_cps.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: cp=%h invalid=%b run_last=%b",
                             got.code_point, got.invalid, got.run_last);
                return;
            end
            want = pending_cps.pop_front();
            if (got.code_point !== want.code_point || got.invalid !== want.invalid ||
                got.run_last !== want.run_last) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("mismatch: expected cp=%h invalid=%b run_last=%b,",
                             want.code_point, want.invalid, want.run_last,
                             " got cp=%h invalid=%b run_last=%b",
                             got.code_point, got.invalid, got.run_last);
            end
        endfunction

        function void finish_check();
            if (pending_cps.size() != 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0d expected results never arrived", pending_cps.size());
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_cycles;
    int   bytes_sent;

    code_point_scoreboard cp_sb;

    utf8_byte_if byte_ch ();
    utf8_cp_if   cp_ch ();

    utf8_byte_stream_decoder u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .cp_ch   (cp_ch)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // monitor both channels
    always @(posedge clk) begin
        result_t got;
        if (rst_n) begin
            if (byte_ch.valid && byte_ch.ready)
                cp_sb.note_byte(byte_ch.byte_in);
            if (cp_ch.valid && cp_ch.ready) begin
                got.code_point = cp_ch.code_point;
                got.invalid    = cp_ch.invalid;
                got.run_last   = cp_ch.run_last;
                cp_sb.check_result(got);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    initial begin
        cp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                cp_ch.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                cp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // offer one byte and wait for its transaction
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.byte_in <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // lead byte plus the first n_cont continuation bytes of a len-byte sequence
    task automatic send_seq(input int len, input logic [CP_W-1:0] v, input int n_cont);
        case (len)
            2:       send_byte(LEAD2_PAT | {3'b0, v[10:6]});
            3:       send_byte(LEAD3_PAT | {4'b0, v[15:12]});
            default: send_byte(LEAD4_PAT | {5'b0, v[20:18]});
        endcase
        for (int k = 0; k < n_cont; k++)
            send_byte(CONT_PAT | {2'b0, v[6*(len-2-k) +: 6]});
    endtask

    // mostly well formed text, with raw payloads, truncations and noise
    task automatic send_random(input int n_bytes);
        int stop_at;
        int pick;
        int len;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            len  = $urandom_range(4, 2);
            if (pick < 30)
                send_byte(BYTE_W'($urandom_range(127, 1)));
            else if (pick < 45)
                send_seq(2, CP_W'($urandom_range(MAX_TWO, MIN_TWO)), 1);
            else if (pick < 58)
                send_seq(3, CP_W'($urandom_range(MAX_THREE, MIN_THREE)), 2);
            else if (pick < 70)
                send_seq(4, CP_W'($urandom_range(MAX_FOUR, MIN_FOUR)), 3);
            else if (pick < 78)
                send_seq(len, CP_W'($urandom), len - 1);
            else if (pick < 86) begin
                // truncated sequence followed by any byte, often end of text
                send_seq(len, CP_W'($urandom), $urandom_range(len - 2, 0));
                if ($urandom_range(3) == 0)
                    send_byte('0);
                else
                    send_byte(BYTE_W'($urandom));
            end else if (pick < 95)
                send_byte(BYTE_W'($urandom));
            else
                send_byte('0);
        end
    endtask

    // main sequence
    initial begin
        cp_sb          = new();
        rst_n          = 1'b0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        bytes_sent     = 0;
        byte_ch.valid   <= 1'b0;
        byte_ch.byte_in <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and special cases
        send_byte(8'h00);                       // end of text while idle
        send_byte(8'h7F);
        send_seq(2, MIN_TWO, 1);
        send_seq(2, 21'h0007F, 1);              // overlong two-byte
        send_seq(3, MAX_THREE, 2);
        send_seq(3, 21'h007FF, 2);              // overlong three-byte
        send_seq(3, 21'h0D800, 2);              // surrogate passes through
        send_seq(4, MAX_FOUR, 3);
        send_seq(4, 21'h110000, 3);             // above the last scalar value
        send_byte(8'h80);                       // stray continuation
        send_byte(8'hFF);                       // invalid lead
        send_seq(2, 21'h000C0, 0);
        send_byte(8'h41);                       // interrupted, then ascii
        send_seq(3, 21'h020AC, 1);
        send_byte(8'h00);                       // end of text flushes the sequence

        // random phases; the long receiver hold-off fills the result queue
        hold_cycles = 300;
        send_random(RANDOM_BYTES / 4);
        send_idle_pct = 53;
        send_random(RANDOM_BYTES / 4);
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        send_random(RANDOM_BYTES / 4);
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        send_random(RANDOM_BYTES / 4);
        byte_ch.valid <= 1'b0;

        // drain
        while (cp_sb.pending_cps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cp_sb.finish_check();
        if (cp_sb.error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== utf8_byte_stream_decoder.f =====
+incdir+rtl/core
rtl/core/utf8_pkg.sv
rtl/core/utf8_byte_if.sv
rtl/core/utf8_cp_if.sv
rtl/core/utf8_byte_stream_decoder.sv
verif/testbench.sv
